// File: hdl/pointer_tracker_event_queue_assert.svh
// Assertion macros shared by the pointer tracker RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef POINTER_TRACKER_EVENT_QUEUE_ASSERT_SVH
`define POINTER_TRACKER_EVENT_QUEUE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define PTQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ptq_pkg.sv
// Shared types and constants for the pointer tracker event queue.
// No dependencies; used by ptq_regs, ptq_axis and the top level.
package ptq_pkg;

    // Queue geometry; pointers count modulo twice the depth
    localparam int QUEUE_DEPTH = 16;
    localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int PTR_W       = $clog2(2 * QUEUE_DEPTH);

    // APB register window
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register reset values
    localparam logic [7:0]         ACCEL_RESET    = 8'd0;
    localparam logic signed [15:0] CLIP_MIN_RESET = 16'sd0;
    localparam logic signed [15:0] CLIP_MAX_X_RESET = 16'sd1024;
    localparam logic signed [15:0] CLIP_MAX_Y_RESET = 16'sd768;

    // Event kinds
    typedef enum logic [1:0] {
        KIND_REL    = 2'd0,
        KIND_ABS    = 2'd1,
        KIND_SCALED = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_ACCELERATION   = 3'd0,
        REG_CLIP_MIN_X     = 3'd1,
        REG_CLIP_MIN_Y     = 3'd2,
        REG_CLIP_MAX_X     = 3'd3,
        REG_CLIP_MAX_Y     = 3'd4,
        REG_SCREEN_PRESENT = 3'd5
    } reg_idx_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [7:0]         acceleration;
        logic signed [15:0] clip_min_x;
        logic signed [15:0] clip_min_y;
        logic signed [15:0] clip_max_x;
        logic signed [15:0] clip_max_y;
        logic               screen_present;
    } cfg_t;

    // One queued button-change entry
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [4:0]         buttons;
        logic [31:0]        msec;
        logic [31:0]        counter;
    } q_entry_t;

endpackage

// File: hdl/ptq_if.sv
// Valid/ready channel interfaces for event transactions and reports.
// No dependencies.
interface ptq_evt_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic [4:0]         button_bits;
    logic [31:0]        timestamp;

    modport source (output valid, kind, coord_x, coord_y, button_bits, timestamp,
                    input ready);
    modport sink (input valid, kind, coord_x, coord_y, button_bits, timestamp,
                  output ready);
endinterface

interface ptq_rpt_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [4:0]         out_buttons;
    logic [31:0]        out_msec;
    logic [31:0]        out_counter;
    logic               from_queue;
    logic               event_dropped;

    modport source (output valid, out_x, out_y, out_buttons, out_msec, out_counter,
                    from_queue, event_dropped, input ready);
    modport sink (input valid, out_x, out_y, out_buttons, out_msec, out_counter,
                  from_queue, event_dropped, output ready);
endinterface

// File: hdl/ptq_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ptq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/ptq_regs.sv
// APB configuration registers of the pointer tracker.
// Depends on ptq_pkg.
module ptq_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ptq_pkg::ADDR_W-1:0]  paddr,
    input  logic [ptq_pkg::DATA_W-1:0]  pwdata,
    output logic [ptq_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ptq_pkg::cfg_t               cfg
);

    ptq_pkg::cfg_t     cfg_reg;
    ptq_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx    = ptq_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.acceleration   <= ptq_pkg::ACCEL_RESET;
            cfg_reg.clip_min_x     <= ptq_pkg::CLIP_MIN_RESET;
            cfg_reg.clip_min_y     <= ptq_pkg::CLIP_MIN_RESET;
            cfg_reg.clip_max_x     <= ptq_pkg::CLIP_MAX_X_RESET;
            cfg_reg.clip_max_y     <= ptq_pkg::CLIP_MAX_Y_RESET;
            cfg_reg.screen_present <= 1'b1;
        end
        else if (wr_en)
        begin
            case (idx)
                ptq_pkg::REG_ACCELERATION:   cfg_reg.acceleration   <= pwdata[7:0];
                ptq_pkg::REG_CLIP_MIN_X:     cfg_reg.clip_min_x     <= pwdata[15:0];
                ptq_pkg::REG_CLIP_MIN_Y:     cfg_reg.clip_min_y     <= pwdata[15:0];
                ptq_pkg::REG_CLIP_MAX_X:     cfg_reg.clip_max_x     <= pwdata[15:0];
                ptq_pkg::REG_CLIP_MAX_Y:     cfg_reg.clip_max_y     <= pwdata[15:0];
                ptq_pkg::REG_SCREEN_PRESENT: cfg_reg.screen_present <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read mux, zero-extended
    always_comb
    begin
        case (idx)
            ptq_pkg::REG_ACCELERATION:   prdata = {24'd0, cfg_reg.acceleration};
            ptq_pkg::REG_CLIP_MIN_X:     prdata = {16'd0, cfg_reg.clip_min_x};
            ptq_pkg::REG_CLIP_MIN_Y:     prdata = {16'd0, cfg_reg.clip_min_y};
            ptq_pkg::REG_CLIP_MAX_X:     prdata = {16'd0, cfg_reg.clip_max_x};
            ptq_pkg::REG_CLIP_MAX_Y:     prdata = {16'd0, cfg_reg.clip_max_y};
            ptq_pkg::REG_SCREEN_PRESENT: prdata = {31'd0, cfg_reg.screen_present};
            default:                     prdata = '0;
        endcase
    end

endmodule

// File: hdl/ptq_axis.sv
// One axis of the motion datapath: multiply stage, then add and clamp.
// Depends on ptq_pkg.
module ptq_axis (
    input  logic               clk,
    input  logic               load,
    input  logic [1:0]         kind,
    input  logic signed [31:0] coord,
    input  logic [7:0]         acceleration,
    input  logic signed [15:0] clip_min,
    input  logic signed [15:0] clip_max,
    input  logic [1:0]         s1_kind,
    input  logic signed [15:0] cur,
    output logic signed [15:0] pos
);

    // ---- stage 1: acceleration or scaling product ----
    logic signed [16:0] span;
    logic [7:0]         maxacc;
    logic               scaled;
    logic               accel_on;
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] prod;
    logic               mag4;
    logic               mag5;
    logic               small_mag;
    logic [7:0]         boost;
    logic [49:0]        boost_ext;
    logic [49:0]        boost_val;
    logic [49:0]        val_next;
    logic [49:0]        val_reg;

    assign span     = {clip_max[15], clip_max} - {clip_min[15], clip_min};
    assign maxacc   = (acceleration < 8'd3) ? 8'd2 : acceleration;
    assign scaled   = (kind == ptq_pkg::KIND_SCALED);
    assign accel_on = (kind == ptq_pkg::KIND_REL) && (acceleration != 8'd0);

    // Shared multiplier: unsigned coordinate times span, or delta times gain
    assign mul_a = scaled ? {1'b0, coord} : {coord[31], coord};
    assign mul_b = scaled ? span : {9'd0, maxacc};
    assign prod  = mul_a * mul_b;

    // Magnitude 4 and 5 get acceleration-based boosts, not the product; sign follows the delta
    assign mag4      = (coord == 32'sd4) || (coord == -32'sd4);
    assign mag5      = (coord == 32'sd5) || (coord == -32'sd5);
    assign small_mag = (coord >= -32'sd3) && (coord <= 32'sd3);
    assign boost     = mag4 ? (8'd6 + {2'd0, acceleration[7:2]})
                            : (8'd9 + {1'b0, acceleration[7:1]});
    assign boost_ext = {42'd0, boost};
    assign boost_val = coord[31] ? (50'd0 - boost_ext) : boost_ext;

    always_comb
    begin
        if (scaled)
        begin
            val_next = prod;
        end
        else if (accel_on && (mag4 || mag5))
        begin
            val_next = boost_val;
        end
        else if (accel_on && !small_mag)
        begin
            val_next = prod;
        end
        else
        begin
            val_next = {{18{coord[31]}}, coord};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            val_reg <= val_next;
        end
    end

    // ---- stage 2: position sum, rounding and clamp ----
    logic [18:0] quot;
    logic        round_up;
    logic [50:0] op_a;
    logic [50:0] op_b;
    logic [50:0] wide;
    logic [50:0] lo_wide;
    logic [50:0] hi_wide;
    logic        below;
    logic        above;
    logic        inverted;
    logic [15:0] top_val;
    logic        s1_scaled;
    logic        s1_rel;

    assign s1_scaled = (s1_kind == ptq_pkg::KIND_SCALED);
    assign s1_rel    = (s1_kind == ptq_pkg::KIND_REL);

    // Round to nearest of product / 2^31, ties broken on the quotient's low bit
    assign quot     = val_reg[49:31];
    assign round_up = val_reg[30] && (val_reg[31] || (val_reg[29:0] != 30'd0));

    assign op_a = s1_scaled ? {{32{quot[18]}}, quot} : {val_reg[49], val_reg};
    always_comb
    begin
        if (s1_rel)
        begin
            op_b = {{35{cur[15]}}, cur};
        end
        else if (s1_scaled)
        begin
            op_b = {{35{clip_min[15]}}, clip_min};
        end
        else
        begin
            op_b = '0;
        end
    end
    assign wide = op_a + op_b + {50'd0, s1_scaled && round_up};

    // Lower bound first, then upper bound
    assign lo_wide  = {{35{clip_min[15]}}, clip_min};
    assign hi_wide  = {{35{clip_max[15]}}, clip_max};
    assign below    = $signed(wide) < $signed(lo_wide);
    assign above    = $signed(wide) >= $signed(hi_wide);
    assign inverted = clip_min >= clip_max;
    assign top_val  = clip_max - 16'd1;

    always_comb
    begin
        if (below)
        begin
            pos = inverted ? top_val : clip_min;
        end
        else if (above)
        begin
            pos = top_val;
        end
        else
        begin
            pos = wide[15:0];
        end
    end

endmodule

// File: hdl/pointer_tracker_event_queue.sv
// Pointer tracker top level: event channel, report channel, APB registers.
// Depends on ptq_pkg, ptq_if, ptq_ram, ptq_regs, ptq_axis and the assert macros.
//
// Every event transaction (relative, absolute or scaled move, or read) yields
// exactly one report transaction, in order. The block takes one event per
// clock while reports are not stalled. The accepting edge loads the event
// register; the output register loads from it when empty or being taken.
// The next event is taken while the previous report waits. Each cycle holds
// one multiplier per axis on the input side and one wide add with the clip
// compares on the commit side. Button-change states go into a synchronous
// RAM of QUEUE_DEPTH entries; a read issues its address on acceptance and
// uses the registered RAM output at commit, with a bypass when the entry is
// written in the issue cycle. The queue needs no clearing after reset.
`include "pointer_tracker_event_queue_assert.svh"

module pointer_tracker_event_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    ptq_evt_if.sink                     evt,
    ptq_rpt_if.source                   rpt,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ptq_pkg::ADDR_W-1:0]  paddr,
    input  logic [ptq_pkg::DATA_W-1:0]  pwdata,
    output logic [ptq_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int PW = ptq_pkg::PTR_W;
    localparam int SW = ptq_pkg::SLOT_W;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(2 * ptq_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [SW-1:0] ptr_slot(input logic [PW-1:0] p);
        logic [PW-1:0] d;
        d = p - PW'(ptq_pkg::QUEUE_DEPTH);
        return (p >= PW'(ptq_pkg::QUEUE_DEPTH)) ? d[SW-1:0] : p[SW-1:0];
    endfunction

    ptq_pkg::cfg_t cfg;

    ptq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---- control state ----
    logic          s1_valid_reg;
    logic [1:0]    s1_kind_reg;
    logic          s1_motion_reg;
    logic          s1_push_reg;
    logic          s1_drop_reg;
    logic          s1_pop_reg;
    logic [SW-1:0] s1_wslot_reg;
    logic [4:0]    s1_buttons_reg;
    logic [31:0]   s1_msec_reg;
    logic          fwd_reg;
    ptq_pkg::q_entry_t fwd_data_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] wr_ptr_reg;
    logic [4:0]    btn_shadow_reg;
    logic          out_valid_reg;

    logic signed [15:0] cur_x_reg;
    logic signed [15:0] cur_y_reg;
    logic [4:0]         cur_buttons_reg;
    logic [31:0]        cur_msec_reg;
    logic [31:0]        update_count_reg;

    logic signed [15:0] out_x_reg;
    logic signed [15:0] out_y_reg;
    logic [4:0]         out_buttons_reg;
    logic [31:0]        out_msec_reg;
    logic [31:0]        out_counter_reg;
    logic               out_from_queue_reg;
    logic               out_dropped_reg;

    // ---- handshake ----
    logic in_ready;
    logic in_acc;
    logic s1_adv;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || rpt.ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_acc   = evt.valid && in_ready;
    assign evt.ready = in_ready;

    // ---- queue decisions at acceptance ----
    logic [SW-1:0] rd_slot;
    logic [SW-1:0] wr_slot;
    logic          q_empty;
    logic          q_full;
    logic          is_read;
    logic          is_motion;
    logic          btn_changed;
    logic          pop_next;
    logic          push_next;
    logic          drop_next;
    logic          fwd_next;
    logic [PW-1:0] occ;

    assign rd_slot     = ptr_slot(rd_ptr_reg);
    assign wr_slot     = ptr_slot(wr_ptr_reg);
    assign q_empty     = (rd_ptr_reg == wr_ptr_reg);
    assign q_full      = (rd_slot == wr_slot) && !q_empty;
    assign is_read     = (evt.kind == ptq_pkg::KIND_READ);
    assign is_motion   = !is_read && cfg.screen_present;
    assign btn_changed = (evt.button_bits != btn_shadow_reg);
    assign pop_next    = is_read && !q_empty;
    assign push_next   = is_motion && btn_changed && !q_full;
    assign drop_next   = is_motion && btn_changed && q_full;
    assign occ = (wr_ptr_reg >= rd_ptr_reg)
               ? (wr_ptr_reg - rd_ptr_reg)
               : (wr_ptr_reg + PW'(2 * ptq_pkg::QUEUE_DEPTH) - rd_ptr_reg);

    // ---- per-axis datapath ----
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;

    ptq_axis u_axis_x (
        .clk          (clk),
        .load         (in_acc),
        .kind         (evt.kind),
        .coord        (evt.coord_x),
        .acceleration (cfg.acceleration),
        .clip_min     (cfg.clip_min_x),
        .clip_max     (cfg.clip_max_x),
        .s1_kind      (s1_kind_reg),
        .cur          (cur_x_reg),
        .pos          (pos_x)
    );

    ptq_axis u_axis_y (
        .clk          (clk),
        .load         (in_acc),
        .kind         (evt.kind),
        .coord        (evt.coord_y),
        .acceleration (cfg.acceleration),
        .clip_min     (cfg.clip_min_y),
        .clip_max     (cfg.clip_max_y),
        .s1_kind      (s1_kind_reg),
        .cur          (cur_y_reg),
        .pos          (pos_y)
    );

    // ---- queue RAM ----
    logic              ram_we;
    ptq_pkg::q_entry_t wr_entry;
    ptq_pkg::q_entry_t rd_entry;
    ptq_pkg::q_entry_t pop_entry;
    logic [31:0]       count_next;
    logic [$bits(ptq_pkg::q_entry_t)-1:0] ram_rdata;

    assign count_next       = update_count_reg + 32'd1;
    assign ram_we           = s1_adv && s1_push_reg;
    assign wr_entry.x       = pos_x;
    assign wr_entry.y       = pos_y;
    assign wr_entry.buttons = s1_buttons_reg;
    assign wr_entry.msec    = s1_msec_reg;
    assign wr_entry.counter = count_next;

    ptq_ram #(
        .WIDTH ($bits(ptq_pkg::q_entry_t)),
        .DEPTH (ptq_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_wslot_reg),
        .wdata (wr_entry),
        .re    (in_acc && pop_next),
        .raddr (rd_slot),
        .rdata (ram_rdata)
    );

    assign rd_entry  = ram_rdata;
    assign pop_entry = fwd_reg ? fwd_data_reg : rd_entry;

    // Pop reads the slot being written in this same cycle
    assign fwd_next = pop_next && ram_we && (s1_wslot_reg == rd_slot);

    // ---- control registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s1_motion_reg    <= 1'b0;
            s1_push_reg      <= 1'b0;
            s1_drop_reg      <= 1'b0;
            s1_pop_reg       <= 1'b0;
            fwd_reg          <= 1'b0;
            rd_ptr_reg       <= '0;
            wr_ptr_reg       <= '0;
            btn_shadow_reg   <= '0;
            out_valid_reg    <= 1'b0;
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            cur_buttons_reg  <= '0;
            cur_msec_reg     <= '0;
            update_count_reg <= '0;
        end
        else
        begin
            // Event stage
            if (in_acc)
            begin
                s1_valid_reg  <= 1'b1;
                s1_motion_reg <= is_motion;
                s1_push_reg   <= push_next;
                s1_drop_reg   <= drop_next;
                s1_pop_reg    <= pop_next;
                fwd_reg       <= fwd_next;
                if (pop_next)
                begin
                    rd_ptr_reg <= ptr_inc(rd_ptr_reg);
                end
                if (push_next)
                begin
                    wr_ptr_reg <= ptr_inc(wr_ptr_reg);
                end
                if (is_motion)
                begin
                    btn_shadow_reg <= evt.button_bits;
                end
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            // Commit of the current state
            if (s1_adv && s1_motion_reg)
            begin
                cur_x_reg        <= pos_x;
                cur_y_reg        <= pos_y;
                cur_buttons_reg  <= s1_buttons_reg;
                cur_msec_reg     <= s1_msec_reg;
                update_count_reg <= count_next;
            end

            // Output register
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rpt.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_kind_reg    <= evt.kind;
            s1_wslot_reg   <= wr_slot;
            s1_buttons_reg <= evt.button_bits;
            s1_msec_reg    <= evt.timestamp;
            fwd_data_reg   <= wr_entry;
        end

        if (s1_adv)
        begin
            if (s1_pop_reg)
            begin
                out_x_reg          <= pop_entry.x;
                out_y_reg          <= pop_entry.y;
                out_buttons_reg    <= pop_entry.buttons;
                out_msec_reg       <= pop_entry.msec;
                out_counter_reg    <= pop_entry.counter;
                out_from_queue_reg <= 1'b1;
                out_dropped_reg    <= 1'b0;
            end
            else if (s1_motion_reg)
            begin
                out_x_reg          <= pos_x;
                out_y_reg          <= pos_y;
                out_buttons_reg    <= s1_buttons_reg;
                out_msec_reg       <= s1_msec_reg;
                out_counter_reg    <= count_next;
                out_from_queue_reg <= 1'b0;
                out_dropped_reg    <= s1_drop_reg;
            end
            else
            begin
                out_x_reg          <= cur_x_reg;
                out_y_reg          <= cur_y_reg;
                out_buttons_reg    <= cur_buttons_reg;
                out_msec_reg       <= cur_msec_reg;
                out_counter_reg    <= update_count_reg;
                out_from_queue_reg <= 1'b0;
                out_dropped_reg    <= 1'b0;
            end
        end
    end

    assign rpt.valid         = out_valid_reg;
    assign rpt.out_x         = out_x_reg;
    assign rpt.out_y         = out_y_reg;
    assign rpt.out_buttons   = out_buttons_reg;
    assign rpt.out_msec      = out_msec_reg;
    assign rpt.out_counter   = out_counter_reg;
    assign rpt.from_queue    = out_from_queue_reg;
    assign rpt.event_dropped = out_dropped_reg;

    // ---- assertions ----
    `PTQ_ASSERT_NOW(a_occ_bound, 1'b1, occ <= PW'(ptq_pkg::QUEUE_DEPTH),
        "queue occupancy exceeds its depth")
    `PTQ_ASSERT_NOW(a_shadow_sync, !s1_valid_reg, btn_shadow_reg == cur_buttons_reg,
        "button shadow out of step with committed buttons")
    `PTQ_ASSERT_NEXT(a_count_step, s1_adv && s1_motion_reg,
        update_count_reg == $past(update_count_reg) + 32'd1,
        "update count did not advance on a committed motion")
    `PTQ_ASSERT_NOW(a_fwd_origin, $rose(fwd_reg), $past(ram_we),
        "read bypass set without a queue write")

endmodule

// File: sim/tb_pointer_tracker_event_queue.sv
// Self-checking testbench for the pointer tracker event queue: motion and read
// transactions with random idling, APB register sweeps, and an in-bench predictor.
// Depends on ptq_pkg, ptq_if and the pointer_tracker_event_queue RTL.
`timescale 1ns / 1ps

module tb_pointer_tracker_event_queue;

    import ptq_pkg::*;

    // One expected or observed report transaction
    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [4:0]         buttons;
        logic [31:0]        msec;
        logic [31:0]        counter;
        logic               from_queue;
        logic               dropped;
    } report_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    ptq_evt_if evt();
    ptq_rpt_if rpt();

    pointer_tracker_event_queue u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt),
        .rpt     (rpt),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: configuration, pointer state, queued button changes
    cfg_t               cfg;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [4:0]         btn_state;
    logic [31:0]        msec_state;
    logic [31:0]        update_cnt;
    q_entry_t           button_history[$];
    report_t            expected_reports[$];

    int error_count  = 0;
    bit idle_enabled = 1'b1;
    int stall_left   = 0;

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop
    initial
    begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Relative move acceleration, sign kept
    function automatic longint accel_delta(longint d);
        longint mag;
        longint gain;
        mag  = (d < 0) ? -d : d;
        gain = (cfg.acceleration < 8'd3) ? 64'sd2 : longint'(cfg.acceleration);
        if (mag == 4)
            mag = 6 + longint'(cfg.acceleration >> 2);
        else if (mag == 5)
            mag = 9 + longint'(cfg.acceleration >> 1);
        else if (mag > 5)
            mag = mag * gain;
        return (d < 0) ? -mag : mag;
    endfunction

    // Map an unsigned coordinate onto the clip span with rounding
    function automatic longint scale_coord(logic [31:0] c, logic signed [15:0] lo,
                                           logic signed [15:0] hi);
        longint span;
        longint prod;
        longint adj;
        span = longint'(hi) - longint'(lo);
        prod = longint'(c) * span;
        adj  = prod[31] ? 64'sd0 : 64'sd1;
        return ((prod + (longint'(1) <<< 30) - adj) >>> 31) + longint'(lo);
    endfunction

    // Lower bound first, then upper; inverted windows land on max-1
    function automatic logic signed [15:0] clamp_coord(longint v, logic signed [15:0] lo,
                                                       logic signed [15:0] hi);
        if (v < longint'(lo))
            v = longint'(lo);
        if (v >= longint'(hi))
            v = longint'(hi) - 1;
        return v[15:0];
    endfunction

    // Update the model for one accepted event and queue its report
    task automatic track_event(kind_t k, logic signed [31:0] cx, logic signed [31:0] cy,
                               logic [4:0] b, logic [31:0] ts);
        report_t  r;
        q_entry_t e;
        longint   nx;
        longint   ny;
        logic     changed;
        r.from_queue = 1'b0;
        r.dropped    = 1'b0;
        if (k != KIND_READ && cfg.screen_present) begin
            if (k == KIND_REL) begin
                nx = longint'(cx);
                ny = longint'(cy);
                if (cfg.acceleration != 8'd0) begin
                    nx = accel_delta(nx);
                    ny = accel_delta(ny);
                end
                nx = nx + longint'(pos_x);
                ny = ny + longint'(pos_y);
            end else if (k == KIND_ABS) begin
                nx = longint'(cx);
                ny = longint'(cy);
            end else begin
                nx = scale_coord(cx, cfg.clip_min_x, cfg.clip_max_x);
                ny = scale_coord(cy, cfg.clip_min_y, cfg.clip_max_y);
            end
            changed    = (b != btn_state);
            pos_x      = clamp_coord(nx, cfg.clip_min_x, cfg.clip_max_x);
            pos_y      = clamp_coord(ny, cfg.clip_min_y, cfg.clip_max_y);
            btn_state  = b;
            msec_state = ts;
            update_cnt = update_cnt + 32'd1;
            if (changed) begin
                if (button_history.size() < QUEUE_DEPTH)
                    button_history.push_back('{pos_x, pos_y, btn_state, msec_state,
                                               update_cnt});
                else
                    r.dropped = 1'b1;
            end
        end
        r.x       = pos_x;
        r.y       = pos_y;
        r.buttons = btn_state;
        r.msec    = msec_state;
        r.counter = update_cnt;
        // Read pops the oldest button change, else reports the live state
        if (k == KIND_READ && button_history.size() != 0) begin
            e            = button_history.pop_front();
            r.x          = e.x;
            r.y          = e.y;
            r.buttons    = e.buttons;
            r.msec       = e.msec;
            r.counter    = e.counter;
            r.from_queue = 1'b1;
        end
        expected_reports.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Report checking
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_reports
        report_t want;
        if (rst_n && rpt.valid && rpt.ready) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected report, expected none, actual x=%h y=%h cnt=%h",
                         $time, rpt.out_x, rpt.out_y, rpt.out_counter);
                error_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("out_x", 32'(want.x), 32'(rpt.out_x));
                check_field("out_y", 32'(want.y), 32'(rpt.out_y));
                check_field("out_buttons", 32'(want.buttons), 32'(rpt.out_buttons));
                check_field("out_msec", want.msec, rpt.out_msec);
                check_field("out_counter", want.counter, rpt.out_counter);
                check_field("from_queue", 32'(want.from_queue), 32'(rpt.from_queue));
                check_field("event_dropped", 32'(want.dropped), 32'(rpt.event_dropped));
            end
        end
    end

    // Report back-pressure: random stalls while idling is enabled
    always @(negedge clk)
    begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            rpt.ready <= 1'b0;
        end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 15);
            rpt.ready <= 1'b0;
        end else begin
            rpt.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Send one event transaction, with an optional idle gap first
    task automatic send_event(kind_t k, logic signed [31:0] cx, logic signed [31:0] cy,
                              logic [4:0] b, logic [31:0] ts);
        @(negedge clk);
        if (idle_enabled && $urandom_range(0, 3) == 0) begin
            evt.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        evt.valid       <= 1'b1;
        evt.kind        <= k;
        evt.coord_x     <= cx;
        evt.coord_y     <= cy;
        evt.button_bits <= b;
        evt.timestamp   <= ts;
        @(posedge clk);
        while (!evt.ready)
            @(posedge clk);
        track_event(k, cx, cy, b, ts);
    endtask

    // Stop sending and let every outstanding report drain
    task automatic wait_drained();
        @(negedge clk);
        evt.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write, then read back and compare the register's bits
    task automatic write_register(reg_idx_t idx, logic [31:0] value);
        logic [31:0] mask;
        case (idx)
            REG_ACCELERATION:   mask = 32'h0000_00FF;
            REG_SCREEN_PRESENT: mask = 32'h0000_0001;
            default:            mask = 32'h0000_FFFF;
        endcase
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if ((prdata & mask) !== (value & mask)) begin
            $display("%0t: register %s readback, expected %h, actual %h",
                     $time, idx.name(), value & mask, prdata & mask);
            error_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ACCELERATION:   cfg.acceleration   = value[7:0];
            REG_CLIP_MIN_X:     cfg.clip_min_x     = value[15:0];
            REG_CLIP_MIN_Y:     cfg.clip_min_y     = value[15:0];
            REG_CLIP_MAX_X:     cfg.clip_max_x     = value[15:0];
            REG_CLIP_MAX_Y:     cfg.clip_max_y     = value[15:0];
            REG_SCREEN_PRESENT: cfg.screen_present = value[0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------

    function automatic logic signed [31:0] small_delta();
        return $urandom_range(0, 16) - 8;
    endfunction

    function automatic logic signed [31:0] random_coord(kind_t k);
        int pick;
        pick = $urandom_range(0, 9);
        case (k)
            KIND_REL:    return (pick < 6) ? small_delta() :
                                (pick < 9) ? $urandom_range(0, 4000) - 2000 : $urandom;
            KIND_ABS:    return (pick < 7) ? $urandom_range(0, 2400) - 1200 : $urandom;
            KIND_SCALED:
            begin
                case (pick)
                    0:       return 32'h0000_0000;
                    1:       return 32'hFFFF_FFFF;
                    2:       return 32'h8000_0000;
                    default: return $urandom;
                endcase
            end
            default:     return $urandom;
        endcase
    endfunction

    task automatic send_random_event();
        kind_t      k;
        logic [4:0] b;
        int         sel;
        sel = $urandom_range(0, 99);
        k = (sel < 35) ? KIND_REL : (sel < 55) ? KIND_ABS :
            (sel < 75) ? KIND_SCALED : KIND_READ;
        sel = $urandom_range(0, 9);
        b = (sel < 3) ? btn_state ^ 5'($urandom_range(1, 31)) :
            (sel < 4) ? 5'($urandom_range(0, 31)) : btn_state;
        send_event(k, random_coord(k), random_coord(k), b, $urandom);
    endtask

    // Mostly mixed traffic, with occasional bursts of button changes that fill the queue
    task automatic run_random(int count);
        int sent;
        int n;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 49) == 0) begin
                n = $urandom_range(17, 20);
                repeat (n)
                    send_event(KIND_REL, small_delta(), small_delta(),
                               btn_state ^ 5'($urandom_range(1, 31)), $urandom);
                sent += n;
            end else begin
                send_random_event();
                sent++;
            end
        end
    endtask

    // Quiesce, program every register, then run random traffic
    task automatic run_phase(logic [7:0] accel, logic [15:0] min_x, logic [15:0] min_y,
                             logic [15:0] max_x, logic [15:0] max_y, logic screen,
                             int count);
        wait_drained();
        write_register(REG_ACCELERATION, 32'(accel));
        write_register(REG_CLIP_MIN_X, 32'(min_x));
        write_register(REG_CLIP_MIN_Y, 32'(min_y));
        write_register(REG_CLIP_MAX_X, 32'(max_x));
        write_register(REG_CLIP_MAX_Y, 32'(max_y));
        write_register(REG_SCREEN_PRESENT, 32'(screen));
        run_random(count);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes and every event kind at the reset configuration
    task automatic test_directed_motion();
        send_event(KIND_READ, 32'sd0, 32'sd0, 5'h00, 32'h0);
        send_event(KIND_ABS, 32'sh8000_0000, 32'sh7FFF_FFFF, 5'h1F, 32'hFFFF_FFFF);
        send_event(KIND_REL, 32'sh7FFF_FFFF, 32'sh8000_0000, 5'h1F, 32'h0);
        send_event(KIND_SCALED, 32'shFFFF_FFFF, 32'sh0000_0000, 5'h00, 32'h1234_5678);
        send_event(KIND_SCALED, 32'sh8000_0000, 32'sh7FFF_FFFF, 5'h00, 32'h8000_0000);
        send_event(KIND_REL, -32'sd4, 32'sd5, 5'h0A, 32'h0000_0001);
        send_event(KIND_REL, 32'sd3, -32'sd3, 5'h0A, 32'h7FFF_FFFF);
        repeat (5)
            send_event(KIND_READ, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 5'h1F, 32'hFFFF_FFFF);
    endtask

    // Seventeen button changes in a row with no reads: the last one is dropped
    task automatic test_queue_overflow();
        for (int i = 0; i < 17; i++)
            send_event(KIND_REL, 32'sd1, 32'sd1, btn_state ^ 5'(1 << (i % 5)), 32'(i));
    endtask

    // Acceleration levels, clip windows (full, inverted, random) and no screen
    task automatic test_config_sweep();
        run_phase(8'd0, 16'd0, 16'd0, 16'd1024, 16'd768, 1'b1, 200);
        run_phase(8'd1, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1, 200);
        run_phase(8'd2, -16'sd500, -16'sd300, 16'sd500, 16'sd300, 1'b1, 200);
        run_phase(8'd3, 16'd0, 16'd0, 16'd1024, 16'd768, 1'b1, 200);
        run_phase(8'd4, -16'sd100, -16'sd100, 16'sd100, 16'sd100, 1'b1, 200);
        run_phase(8'd255, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1, 200);
        // Inverted and degenerate windows
        run_phase(8'd7, 16'sd100, 16'sd5, -16'sd100, 16'sd5, 1'b1, 150);
        run_phase(8'd128, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b1, 100);
        // Screen absent: motion is ignored
        run_phase(8'd255, 16'd0, 16'd0, 16'd1024, 16'd768, 1'b0, 100);
        repeat (3)
            run_phase(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 1'b1, 150);
    endtask

    // Back-to-back traffic with neither side idling
    task automatic test_steady_stream();
        wait_drained();
        idle_enabled = 1'b0;
        run_phase(8'd5, -16'sd640, -16'sd480, 16'sd640, 16'sd480, 1'b1, 200);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        evt.valid       = 1'b0;
        evt.kind        = KIND_REL;
        evt.coord_x     = '0;
        evt.coord_y     = '0;
        evt.button_bits = '0;
        evt.timestamp   = '0;
        rpt.ready       = 1'b0;
        cfg             = '{ACCEL_RESET, CLIP_MIN_RESET, CLIP_MIN_RESET,
                            CLIP_MAX_X_RESET, CLIP_MAX_Y_RESET, 1'b1};
        pos_x           = '0;
        pos_y           = '0;
        btn_state       = '0;
        msec_state      = '0;
        update_cnt      = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_motion();
        test_queue_overflow();
        test_config_sweep();
        test_steady_stream();

        wait_drained();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
